FILE: rtl/drs_pkg.sv
// Shared widths, command and status codes, cell control and FSM state types for the scheduler.
package drs_pkg;

  localparam int RING_DEPTH_DEF    = 16;
  localparam int DEADLINE_BITS_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 8;
  localparam int START_W  = 32;
  localparam int PERIOD_W = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CO_HOLD  = 3'd0,
    CO_WRITE = 3'd1,
    CO_TICK  = 3'd2,
    CO_POP   = 3'd3,
    CO_SWAP  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wr_en;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

FILE: rtl/drs_if.sv
// Valid/ready channel interfaces for scheduler commands and results.
interface drs_in_if;
  logic                                valid;
  logic                                ready;
  logic        [drs_pkg::CMD_W-1:0]    cmd;
  logic        [drs_pkg::ID_W-1:0]     task_id;
  logic signed [drs_pkg::START_W-1:0]  start_deadline;
  logic        [drs_pkg::PERIOD_W-1:0] task_period;
  logic                                repeat_task;

  modport source (output valid, cmd, task_id, start_deadline, task_period, repeat_task,
                  input ready);
  modport sink   (input valid, cmd, task_id, start_deadline, task_period, repeat_task,
                  output ready);
endinterface

interface drs_out_if;
  logic                                valid;
  logic                                ready;
  logic        [drs_pkg::STATUS_W-1:0] status;
  logic        [drs_pkg::ID_W-1:0]     chosen_id;
  logic                                due;

  modport source (output valid, status, chosen_id, due, input ready);
  modport sink   (input valid, status, chosen_id, due, output ready);
endinterface

FILE: rtl/drs_cell.sv
// One task slot of the scheduler chain with its stage of the earliest-deadline search token.
module drs_cell #(
  parameter int RING_DEPTH    = drs_pkg::RING_DEPTH_DEF,
  parameter int DEADLINE_BITS = drs_pkg::DEADLINE_BITS_DEF,
  parameter int CELL_IDX      = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  drs_pkg::cell_ctl_t                  ctl,
  input  logic        [$clog2(RING_DEPTH)-1:0] count,
  input  logic        [$clog2(RING_DEPTH)-1:0] wr_idx,
  input  logic        [drs_pkg::ID_W-1:0]     wr_id,
  input  logic signed [DEADLINE_BITS-1:0]     wr_dl,
  input  logic        [drs_pkg::PERIOD_W-1:0] wr_per,
  input  logic        [drs_pkg::ID_W-1:0]     nxt_id,
  input  logic signed [DEADLINE_BITS-1:0]     nxt_dl,
  input  logic        [drs_pkg::PERIOD_W-1:0] nxt_per,
  input  logic        [drs_pkg::ID_W-1:0]     head_id,
  input  logic signed [DEADLINE_BITS-1:0]     head_dl,
  input  logic        [drs_pkg::PERIOD_W-1:0] head_per,
  input  logic                                tok_in_vld,
  input  logic        [$clog2(RING_DEPTH)-1:0] tok_in_idx,
  input  logic        [drs_pkg::ID_W-1:0]     tok_in_id,
  input  logic signed [DEADLINE_BITS-1:0]     tok_in_dl,
  input  logic        [drs_pkg::PERIOD_W-1:0] tok_in_per,
  output logic        [drs_pkg::ID_W-1:0]     ent_id,
  output logic signed [DEADLINE_BITS-1:0]     ent_dl,
  output logic        [drs_pkg::PERIOD_W-1:0] ent_per,
  output logic                                tok_out_vld,
  output logic        [$clog2(RING_DEPTH)-1:0] tok_out_idx,
  output logic        [drs_pkg::ID_W-1:0]     tok_out_id,
  output logic signed [DEADLINE_BITS-1:0]     tok_out_dl,
  output logic        [drs_pkg::PERIOD_W-1:0] tok_out_per
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic signed [DEADLINE_BITS-1:0] DL_MIN = {1'b1, {(DEADLINE_BITS-1){1'b0}}};

  logic        [drs_pkg::ID_W-1:0]     ent_id_r,  ent_id_nxt;
  logic signed [DEADLINE_BITS-1:0]     ent_dl_r,  ent_dl_nxt;
  logic        [drs_pkg::PERIOD_W-1:0] ent_per_r, ent_per_nxt;

  logic                                tok_vld_r;
  logic        [IDX_W-1:0]             tok_idx_r, tok_idx_nxt;
  logic        [drs_pkg::ID_W-1:0]     tok_id_r,  tok_id_nxt;
  logic signed [DEADLINE_BITS-1:0]     tok_dl_r,  tok_dl_nxt;
  logic        [drs_pkg::PERIOD_W-1:0] tok_per_r, tok_per_nxt;

  logic occupied;
  logic wr_hit;
  logic take_own;

  assign occupied = (MY_IDX < count);
  assign wr_hit   = (wr_idx == MY_IDX);

  always_comb begin
    ent_id_nxt  = ent_id_r;
    ent_dl_nxt  = ent_dl_r;
    ent_per_nxt = ent_per_r;
    case (ctl.op)
      drs_pkg::CO_WRITE: begin
        if (wr_hit) begin
          ent_id_nxt  = wr_id;
          ent_dl_nxt  = wr_dl;
          ent_per_nxt = wr_per;
        end
      end
      drs_pkg::CO_TICK: begin
        // stop at the most negative deadline
        if (occupied && (ent_dl_r != DL_MIN)) begin
          ent_dl_nxt = ent_dl_r - 1'b1;
        end
      end
      drs_pkg::CO_POP: begin
        if (ctl.wr_en && wr_hit) begin
          ent_id_nxt  = wr_id;
          ent_dl_nxt  = wr_dl;
          ent_per_nxt = wr_per;
        end else begin
          ent_id_nxt  = nxt_id;
          ent_dl_nxt  = nxt_dl;
          ent_per_nxt = nxt_per;
        end
      end
      drs_pkg::CO_SWAP: begin
        // head takes the winner, winner's slot takes the old head
        if (MY_IDX == '0) begin
          ent_id_nxt  = wr_id;
          ent_dl_nxt  = wr_dl;
          ent_per_nxt = wr_per;
        end else if (wr_hit) begin
          ent_id_nxt  = head_id;
          ent_dl_nxt  = head_dl;
          ent_per_nxt = head_per;
        end
      end
      default: begin
      end
    endcase
  end

  // strict compare keeps the earliest slot on ties
  assign take_own = occupied && ((MY_IDX == '0) || (ent_dl_r < tok_in_dl));

  always_comb begin
    if (take_own) begin
      tok_idx_nxt = MY_IDX;
      tok_id_nxt  = ent_id_r;
      tok_dl_nxt  = ent_dl_r;
      tok_per_nxt = ent_per_r;
    end else begin
      tok_idx_nxt = tok_in_idx;
      tok_id_nxt  = tok_in_id;
      tok_dl_nxt  = tok_in_dl;
      tok_per_nxt = tok_in_per;
    end
  end

  always_ff @(posedge clk) begin
    ent_id_r  <= ent_id_nxt;
    ent_dl_r  <= ent_dl_nxt;
    ent_per_r <= ent_per_nxt;
    tok_idx_r <= tok_idx_nxt;
    tok_id_r  <= tok_id_nxt;
    tok_dl_r  <= tok_dl_nxt;
    tok_per_r <= tok_per_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_in_vld;
    end
  end

  assign ent_id      = ent_id_r;
  assign ent_dl      = ent_dl_r;
  assign ent_per     = ent_per_r;
  assign tok_out_vld = tok_vld_r;
  assign tok_out_idx = tok_idx_r;
  assign tok_out_id  = tok_id_r;
  assign tok_out_dl  = tok_dl_r;
  assign tok_out_per = tok_per_r;

endmodule

FILE: rtl/deadline_ring_scheduler.sv
// Earliest-deadline-first task scheduler built on a chain of task slot cells.
// Add, tick and finish act on the ring when accepted; the result passes through the
// pending register and the output register to out_ch. Select walks the search token
// one cell per cycle down the chain, then swaps the winner to the head; a new word is
// taken only once the last word's result has left the pending register.
// Reset empties the ring (fill count 0) and clears all valids; slot contents are not reset.
module deadline_ring_scheduler #(
  parameter int RING_DEPTH    = drs_pkg::RING_DEPTH_DEF,
  parameter int DEADLINE_BITS = drs_pkg::DEADLINE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  drs_in_if.sink   in_ch,
  drs_out_if.source out_ch
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int DB    = DEADLINE_BITS;
  localparam int SAT_W = (DB > drs_pkg::START_W) ? DB : drs_pkg::START_W;
  localparam int SUM_W = ((DB > drs_pkg::PERIOD_W) ? DB : drs_pkg::PERIOD_W) + 2;
  localparam logic signed [DB-1:0] DL_MAX = {1'b0, {(DB-1){1'b1}}};
  localparam logic signed [DB-1:0] DL_MIN = {1'b1, {(DB-1){1'b0}}};
  localparam logic [IDX_W-1:0] FULL_CNT = IDX_W'(RING_DEPTH - 1);

  function automatic logic signed [DB-1:0] add_period(
    input logic signed [DB-1:0]            d,
    input logic [drs_pkg::PERIOD_W-1:0]    p
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(d) + $signed({{(SUM_W-drs_pkg::PERIOD_W){1'b0}}, p});
    if (s > SUM_W'(DL_MAX)) begin
      return DL_MAX;
    end
    return s[DB-1:0];
  endfunction

  // cell chain wiring
  logic        [drs_pkg::ID_W-1:0]     ent_id  [RING_DEPTH];
  logic signed [DB-1:0]                ent_dl  [RING_DEPTH];
  logic        [drs_pkg::PERIOD_W-1:0] ent_per [RING_DEPTH];
  logic                                tok_vld [RING_DEPTH];
  logic        [IDX_W-1:0]             tok_idx [RING_DEPTH];
  logic        [drs_pkg::ID_W-1:0]     tok_id  [RING_DEPTH];
  logic signed [DB-1:0]                tok_dl  [RING_DEPTH];
  logic        [drs_pkg::PERIOD_W-1:0] tok_per [RING_DEPTH];

  drs_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]   count_r, count_nxt;
  drs_pkg::cell_ctl_t ctl;
  logic [IDX_W-1:0]   wr_idx;
  logic [drs_pkg::ID_W-1:0]     wr_id;
  logic signed [DB-1:0]         wr_dl;
  logic [drs_pkg::PERIOD_W-1:0] wr_per;
  logic                         tok_start;

  logic signed [SAT_W-1:0]      sd_w;
  logic signed [DB-1:0]         sd;
  logic signed [DB-1:0]         ap_dl;
  logic [drs_pkg::PERIOD_W-1:0] ap_per;
  logic signed [DB-1:0]         ap_sum;

  logic                         in_ready;
  logic                         accept;
  logic                         full;
  logic                         empty;
  drs_pkg::cmd_t                cmd;

  logic                         pend_load;
  drs_pkg::status_t             pend_status_nxt;
  logic [drs_pkg::ID_W-1:0]     pend_id_nxt;
  logic                         pend_due_nxt;
  logic                         pend_valid_r;
  drs_pkg::status_t             pend_status_r;
  logic [drs_pkg::ID_W-1:0]     pend_id_r;
  logic                         pend_due_r;
  logic                         pend_move;

  logic                         out_valid_r;
  drs_pkg::status_t             out_status_r;
  logic [drs_pkg::ID_W-1:0]     out_id_r;
  logic                         out_due_r;

  logic                         last_vld;
  logic [IDX_W-1:0]             last_idx;
  logic [drs_pkg::ID_W-1:0]     last_id;
  logic signed [DB-1:0]         last_dl;
  logic [drs_pkg::PERIOD_W-1:0] last_per;

  assign in_ready = (state_r == drs_pkg::ST_IDLE) && !pend_valid_r;
  assign accept   = in_ch.valid && in_ready;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign cmd      = drs_pkg::cmd_t'(in_ch.cmd);

  assign last_vld = tok_vld[RING_DEPTH-1];
  assign last_idx = tok_idx[RING_DEPTH-1];
  assign last_id  = tok_id[RING_DEPTH-1];
  assign last_dl  = tok_dl[RING_DEPTH-1];
  assign last_per = tok_per[RING_DEPTH-1];

  // clamp the start deadline into the deadline range
  always_comb begin
    sd_w = SAT_W'(in_ch.start_deadline);
    if (sd_w > SAT_W'(DL_MAX)) begin
      sd = DL_MAX;
    end else if (sd_w < SAT_W'(DL_MIN)) begin
      sd = DL_MIN;
    end else begin
      sd = sd_w[DB-1:0];
    end
  end

  // one saturating adder shared by add and re-queue
  always_comb begin
    if (cmd == drs_pkg::CMD_FINISH) begin
      ap_dl  = ent_dl[0];
      ap_per = ent_per[0];
    end else begin
      ap_dl  = sd;
      ap_per = in_ch.task_period;
    end
    ap_sum = add_period(ap_dl, ap_per);
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ctl.op          = drs_pkg::CO_HOLD;
    ctl.wr_en       = 1'b0;
    wr_idx          = count_r;
    wr_id           = in_ch.task_id;
    wr_dl           = ap_sum;
    wr_per          = ap_per;
    tok_start       = 1'b0;
    pend_load       = 1'b0;
    pend_status_nxt = drs_pkg::STAT_OK;
    pend_id_nxt     = '0;
    pend_due_nxt    = 1'b0;
    case (state_r)
      drs_pkg::ST_IDLE: begin
        if (accept) begin
          pend_load = 1'b1;
          case (cmd)
            drs_pkg::CMD_ADD: begin
              if (full) begin
                pend_status_nxt = drs_pkg::STAT_FULL;
              end else begin
                ctl.op    = drs_pkg::CO_WRITE;
                count_nxt = count_r + 1'b1;
              end
            end
            drs_pkg::CMD_TICK: begin
              ctl.op = drs_pkg::CO_TICK;
            end
            drs_pkg::CMD_SELECT: begin
              if (empty) begin
                pend_status_nxt = drs_pkg::STAT_EMPTY;
              end else begin
                pend_load = 1'b0;
                tok_start = 1'b1;
                state_nxt = drs_pkg::ST_SCAN;
              end
            end
            drs_pkg::CMD_FINISH: begin
              if (empty) begin
                pend_status_nxt = drs_pkg::STAT_EMPTY;
              end else begin
                ctl.op = drs_pkg::CO_POP;
                wr_idx = count_r - 1'b1;
                wr_id  = ent_id[0];
                if (in_ch.repeat_task && !full) begin
                  // pop and append in one shift; fill count holds
                  ctl.wr_en = 1'b1;
                end else begin
                  count_nxt = count_r - 1'b1;
                  if (in_ch.repeat_task) begin
                    pend_status_nxt = drs_pkg::STAT_FULL;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      drs_pkg::ST_SCAN: begin
        if (last_vld) begin
          ctl.op       = drs_pkg::CO_SWAP;
          wr_idx       = last_idx;
          wr_id        = last_id;
          wr_dl        = last_dl;
          wr_per       = last_per;
          pend_load    = 1'b1;
          pend_id_nxt  = last_id;
          pend_due_nxt = last_dl[DB-1] || (last_dl == '0);
          state_nxt    = drs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = drs_pkg::ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    logic        [drs_pkg::ID_W-1:0]     n_id;
    logic signed [DB-1:0]                n_dl;
    logic        [drs_pkg::PERIOD_W-1:0] n_per;
    logic                                t_vld;
    logic        [IDX_W-1:0]             t_idx;
    logic        [drs_pkg::ID_W-1:0]     t_id;
    logic signed [DB-1:0]                t_dl;
    logic        [drs_pkg::PERIOD_W-1:0] t_per;

    if (i < RING_DEPTH - 1) begin : g_nxt
      assign n_id  = ent_id[i+1];
      assign n_dl  = ent_dl[i+1];
      assign n_per = ent_per[i+1];
    end else begin : g_last
      assign n_id  = ent_id[i];
      assign n_dl  = ent_dl[i];
      assign n_per = ent_per[i];
    end

    if (i == 0) begin : g_tok_head
      assign t_vld = tok_start;
      assign t_idx = '0;
      assign t_id  = '0;
      assign t_dl  = '0;
      assign t_per = '0;
    end else begin : g_tok_chain
      assign t_vld = tok_vld[i-1];
      assign t_idx = tok_idx[i-1];
      assign t_id  = tok_id[i-1];
      assign t_dl  = tok_dl[i-1];
      assign t_per = tok_per[i-1];
    end

    drs_cell #(
      .RING_DEPTH    (RING_DEPTH),
      .DEADLINE_BITS (DEADLINE_BITS),
      .CELL_IDX      (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .count       (count_r),
      .wr_idx      (wr_idx),
      .wr_id       (wr_id),
      .wr_dl       (wr_dl),
      .wr_per      (wr_per),
      .nxt_id      (n_id),
      .nxt_dl      (n_dl),
      .nxt_per     (n_per),
      .head_id     (ent_id[0]),
      .head_dl     (ent_dl[0]),
      .head_per    (ent_per[0]),
      .tok_in_vld  (t_vld),
      .tok_in_idx  (t_idx),
      .tok_in_id   (t_id),
      .tok_in_dl   (t_dl),
      .tok_in_per  (t_per),
      .ent_id      (ent_id[i]),
      .ent_dl      (ent_dl[i]),
      .ent_per     (ent_per[i]),
      .tok_out_vld (tok_vld[i]),
      .tok_out_idx (tok_idx[i]),
      .tok_out_id  (tok_id[i]),
      .tok_out_dl  (tok_dl[i]),
      .tok_out_per (tok_per[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // pending word feeds the output register
  assign pend_move = pend_valid_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (pend_move) begin
        pend_valid_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_status_r <= pend_status_nxt;
      pend_id_r     <= pend_id_nxt;
      pend_due_r    <= pend_due_nxt;
    end
    if (pend_move) begin
      out_status_r <= pend_status_r;
      out_id_r     <= pend_id_r;
      out_due_r    <= pend_due_r;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.chosen_id = out_id_r;
  assign out_ch.due       = out_due_r;

endmodule

FILE: rtl/drs_checker.sv
// Port-level assertions for the deadline scheduler and the bind that attaches them.
module drs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [drs_pkg::STATUS_W-1:0] out_status,
  input logic [drs_pkg::ID_W-1:0]     out_chosen_id,
  input logic                         out_due
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one command in flight: ready drops after each accepted word
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command accepted back to back");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == drs_pkg::STAT_OK) || (out_status == drs_pkg::STAT_FULL) ||
                  (out_status == drs_pkg::STAT_EMPTY))
    else $error("undefined status code");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != drs_pkg::STAT_OK) |-> (out_chosen_id == '0) && !out_due)
    else $error("failed command reports a chosen task");

endmodule

bind deadline_ring_scheduler drs_checker u_drs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_chosen_id (out_ch.chosen_id),
  .out_due       (out_ch.due)
);

FILE: sim/deadline_ring_scheduler_tb.sv
// Self-checking testbench for the deadline ring scheduler: ring predictor, random words.
module deadline_ring_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DEPTH       = drs_pkg::RING_DEPTH_DEF;
  localparam longint DL_MAX      = 64'sd2147483647;
  localparam longint DL_MIN      = -DL_MAX - 1;
  localparam int     DRAIN_CYCS  = 2 * DEPTH + 8;
  localparam int     LONG_HOLD   = 80;
  localparam int     PHASE_WORDS = 150;

  typedef struct packed {
    drs_pkg::status_t         status;
    logic [drs_pkg::ID_W-1:0] chosen;
    logic                     due;
  } reply_t;

  // Ring of tasks mirrored from the block, plus the replies it owes.
  class deadline_book;
    logic [drs_pkg::ID_W-1:0]     ids[DEPTH];
    longint                       dls[DEPTH];
    logic [drs_pkg::PERIOD_W-1:0] pers[DEPTH];
    int unsigned                  head;
    int unsigned                  tail;
    reply_t                       owed[$];
    int                           errors;

    function new();
      head   = 0;
      tail   = 0;
      errors = 0;
    endfunction

    function int unsigned occupancy();
      return (tail + DEPTH - head) % DEPTH;
    endfunction

    function int unsigned step(int unsigned p);
      return (p + 1) % DEPTH;
    endfunction

    function longint advance(longint d, logic [drs_pkg::PERIOD_W-1:0] p);
      if (d > DL_MAX - longint'(p)) return DL_MAX;
      return d + longint'(p);
    endfunction

    function bit append(logic [drs_pkg::ID_W-1:0] id, longint d,
                        logic [drs_pkg::PERIOD_W-1:0] p);
      if (step(tail) == head) return 1'b0;
      ids[tail]  = id;
      dls[tail]  = advance(d, p);
      pers[tail] = p;
      tail       = step(tail);
      return 1'b1;
    endfunction

    function void note_word(drs_pkg::cmd_t c, logic [drs_pkg::ID_W-1:0] id,
                            logic [drs_pkg::START_W-1:0] sd,
                            logic [drs_pkg::PERIOD_W-1:0] per, logic rep);
      reply_t                       r;
      int unsigned                  p;
      int unsigned                  best;
      logic [drs_pkg::ID_W-1:0]     t_id;
      longint                       t_dl;
      logic [drs_pkg::PERIOD_W-1:0] t_per;
      r = '{status: drs_pkg::STAT_OK, chosen: '0, due: 1'b0};
      if (c == drs_pkg::CMD_ADD) begin
        if (!append(id, longint'($signed(sd)), per)) r.status = drs_pkg::STAT_FULL;
      end else if (c == drs_pkg::CMD_TICK) begin
        for (p = head; p != tail; p = step(p))
          if (dls[p] > DL_MIN) dls[p] = dls[p] - 1;
      end else if (head == tail) begin
        r.status = drs_pkg::STAT_EMPTY;
      end else if (c == drs_pkg::CMD_SELECT) begin
        best = head;
        // strict compare keeps the earliest entry on ties
        for (p = step(head); p != tail; p = step(p))
          if (dls[p] < dls[best]) best = p;
        if (best != head) begin
          t_id  = ids[best];  t_dl = dls[best];  t_per = pers[best];
          ids[best]  = ids[head];
          dls[best]  = dls[head];
          pers[best] = pers[head];
          ids[head]  = t_id;  dls[head] = t_dl;  pers[head] = t_per;
        end
        r.chosen = ids[head];
        r.due    = (dls[head] <= 0);
      end else begin
        if (rep && !append(ids[head], dls[head], pers[head])) r.status = drs_pkg::STAT_FULL;
        head = step(head);
      end
      owed.push_back(r);
    endfunction

    function void check_reply(logic [drs_pkg::STATUS_W-1:0] st,
                              logic [drs_pkg::ID_W-1:0] id, logic due);
      reply_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result status=%0d chosen_id=%0d due=%0b",
                 $time, st, id, due);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (id !== e.chosen) begin
        $display("%0t: chosen_id mismatch expected %0d actual %0d", $time, e.chosen, id);
        errors++;
      end
      if (due !== e.due) begin
        $display("%0t: due mismatch expected %0b actual %0b", $time, e.due, due);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   hold_off_req;

  drs_in_if  in_ch();
  drs_out_if out_ch();

  deadline_ring_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deadline_book book = new();

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      book.note_word(drs_pkg::cmd_t'(in_ch.cmd), in_ch.task_id, in_ch.start_deadline,
                     in_ch.task_period, in_ch.repeat_task);
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_reply(out_ch.status, out_ch.chosen_id, out_ch.due);
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (LONG_HOLD) @(negedge clk) out_ch.ready <= 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, 3);
      repeat (gap) @(negedge clk) out_ch.ready <= 1'b0;
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  task automatic send_word(drs_pkg::cmd_t c, logic [drs_pkg::ID_W-1:0] id,
                           logic [drs_pkg::START_W-1:0] sd,
                           logic [drs_pkg::PERIOD_W-1:0] per, logic rep);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= c;
    in_ch.task_id        <= id;
    in_ch.start_deadline <= sd;
    in_ch.task_period    <= per;
    in_ch.repeat_task    <= rep;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid, then hold until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (book.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCS) @(posedge clk);
  endtask

  function automatic logic [drs_pkg::START_W-1:0] pick_deadline();
    int unsigned k;
    k = $urandom_range(0, 9);
    case (k)
      5:       return $urandom;
      6:       return 32'h7FFF_FFFF - $urandom_range(0, 70000);
      7:       return 32'h8000_0000 + $urandom_range(0, 3);
      8:       return $urandom_range(0, 1000);
      9:       return -$urandom_range(0, 1000);
      default: return $urandom_range(0, 60) - 30;
    endcase
  endfunction

  function automatic logic [drs_pkg::PERIOD_W-1:0] pick_period();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 20));
  endfunction

  task automatic random_phase(int add_pct);
    int            r;
    drs_pkg::cmd_t c;
    repeat (PHASE_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        c = drs_pkg::CMD_ADD;
      end else begin
        r = $urandom_range(0, 99);
        c = (r < 35) ? drs_pkg::CMD_TICK : (r < 70) ? drs_pkg::CMD_SELECT :
                                                      drs_pkg::CMD_FINISH;
      end
      send_word(c, 8'($urandom_range(0, 255)), pick_deadline(), pick_period(),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int i;
    rst_n                = 1'b0;
    quiet                = 1'b0;
    hold_off_req         = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = drs_pkg::CMD_TICK;
    in_ch.task_id        = '0;
    in_ch.start_deadline = '0;
    in_ch.task_period    = '0;
    in_ch.repeat_task    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty ring on select, finish and tick
    send_word(drs_pkg::CMD_SELECT, 8'h11, '0, '0, 1'b0);
    send_word(drs_pkg::CMD_FINISH, 8'h22, '0, '0, 1'b1);
    send_word(drs_pkg::CMD_TICK,   8'h33, '0, '0, 1'b0);
    // deadline extremes: saturate high, stop at the bottom on tick
    send_word(drs_pkg::CMD_ADD, 8'hFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_word(drs_pkg::CMD_ADD, 8'h00, 32'h8000_0000, 16'h0000, 1'b1);
    send_word(drs_pkg::CMD_TICK, 8'h00, '0, '0, 1'b0);
    send_word(drs_pkg::CMD_SELECT, 8'h00, '0, '0, 1'b0);
    send_word(drs_pkg::CMD_FINISH, 8'h00, '0, '0, 1'b1);
    // pop head without a select first
    send_word(drs_pkg::CMD_FINISH, 8'h00, '0, '0, 1'b0);
    send_word(drs_pkg::CMD_FINISH, 8'h00, '0, '0, 1'b0);
    // fill with equal deadlines: ties go to the head; last add hits a full ring
    for (i = 0; i < DEPTH; i++)
      send_word(drs_pkg::CMD_ADD, 8'hA0 + i[7:0], '0, '0, 1'b1);
    send_word(drs_pkg::CMD_SELECT, 8'h00, '0, '0, 1'b0);
    // re-queue into a full ring loses the task
    send_word(drs_pkg::CMD_FINISH, 8'h00, '0, '0, 1'b1);
    drain();

    random_phase(55);
    random_phase(30);
    drain();
    quiet = 1'b1;
    random_phase(40);
    quiet = 1'b0;
    hold_off_req = 1'b1;
    random_phase(60);
    random_phase(30);
    drain();
    random_phase(45);
    drain();

    if (book.owed.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, book.owed.size());
    if (book.errors == 0 && book.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/drs_pkg.sv
rtl/drs_if.sv
rtl/drs_cell.sv
rtl/deadline_ring_scheduler.sv
rtl/drs_checker.sv
sim/deadline_ring_scheduler_tb.sv
